// File: design/csl_pkg.sv
// Package for the C subset lexer: token kind codes, character codes, scan modes,
// result entry type and the keyword table with its lookup functions.
// Depends on nothing; used by c_subset_lexer_top.
package csl_pkg;

    localparam int POSITION_BITS_DEF = 20;
    localparam int FIELD_BITS        = 20;
    localparam int KIND_BITS         = 6;
    localparam int PREFIX_BYTES      = 8;
    localparam int KEYWORD_COUNT     = 11;

    // Token kinds
    localparam logic [KIND_BITS-1:0] KIND_END      = 6'd0;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 6'd1;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 6'd2;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 6'd3;
    localparam logic [KIND_BITS-1:0] KIND_LBRACKET = 6'd4;
    localparam logic [KIND_BITS-1:0] KIND_RBRACKET = 6'd5;
    localparam logic [KIND_BITS-1:0] KIND_EQ       = 6'd6;
    localparam logic [KIND_BITS-1:0] KIND_GE       = 6'd7;
    localparam logic [KIND_BITS-1:0] KIND_GT       = 6'd8;
    localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd9;
    localparam logic [KIND_BITS-1:0] KIND_KW_BASE  = 6'd10;
    localparam logic [KIND_BITS-1:0] KIND_LE       = 6'd22;
    localparam logic [KIND_BITS-1:0] KIND_LT       = 6'd23;
    localparam logic [KIND_BITS-1:0] KIND_INT      = 6'd24;
    localparam logic [KIND_BITS-1:0] KIND_MINUS    = 6'd26;
    localparam logic [KIND_BITS-1:0] KIND_NE       = 6'd27;
    localparam logic [KIND_BITS-1:0] KIND_NOT      = 6'd28;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 6'd29;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 6'd30;
    localparam logic [KIND_BITS-1:0] KIND_PERCENT  = 6'd31;
    localparam logic [KIND_BITS-1:0] KIND_PLUS     = 6'd32;
    localparam logic [KIND_BITS-1:0] KIND_SEMI     = 6'd33;
    localparam logic [KIND_BITS-1:0] KIND_SLASH    = 6'd34;
    localparam logic [KIND_BITS-1:0] KIND_STAR     = 6'd35;
    localparam logic [KIND_BITS-1:0] KIND_ERROR    = 6'd36;

    // Held operator codes
    localparam logic [1:0] OP_BANG = 2'd0;
    localparam logic [1:0] OP_EQ   = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    // Character codes that steer the scan
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_NUMBER   = 4'b0010,
        MODE_WORD     = 4'b0100,
        MODE_OPERATOR = 4'b1000
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  last;
    } token_t;

    // Keyword text, first byte lowest, and lengths
    localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
        64'h0000_006b_6165_7262,  // break
        64'h0000_0000_7261_6863,  // char
        64'h6575_6e69_746e_6f63,  // continue
        64'h0000_0000_6573_6c65,  // else
        64'h0000_0000_0072_6f66,  // for
        64'h0000_0000_0000_6669,  // if
        64'h0000_0000_0074_6e69,  // int
        64'h0000_0000_676e_6f6c,  // long
        64'h0000_6e72_7574_6572,  // return
        64'h0000_666f_657a_6973,  // sizeof
        64'h0000_7463_7572_7473   // struct
    };
    localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd5, 4'd4, 4'd8, 4'd4, 4'd3, 4'd2, 4'd3, 4'd4, 4'd6, 4'd6, 4'd6
    };

    // Word kind from prefix; len_code is the word length, or 15 when above 8
    function automatic logic [KIND_BITS-1:0] word_kind(input logic [63:0] prefix,
                                                       input logic [3:0]  len_code);
        logic [KIND_BITS-1:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (len_code == KW_LEN[k] && prefix == KW_TEXT[k]) begin
                kind = KIND_KW_BASE + KIND_BITS'(k);
            end
        end
        return kind;
    endfunction

    // Single-character punctuators; KIND_END where the byte is not one
    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] kind;
        case (c)
            "(": kind = KIND_LPAREN;
            ")": kind = KIND_RPAREN;
            "{": kind = KIND_LBRACE;
            "}": kind = KIND_RBRACE;
            "[": kind = KIND_LBRACKET;
            "]": kind = KIND_RBRACKET;
            ";": kind = KIND_SEMI;
            "+": kind = KIND_PLUS;
            "-": kind = KIND_MINUS;
            "*": kind = KIND_STAR;
            "/": kind = KIND_SLASH;
            "%": kind = KIND_PERCENT;
            default: kind = KIND_END;
        endcase
        return kind;
    endfunction

    function automatic logic [KIND_BITS-1:0] op_single(input logic [1:0] op);
        logic [KIND_BITS-1:0] kind;
        case (op)
            OP_BANG: kind = KIND_NOT;
            OP_EQ:   kind = KIND_ASSIGN;
            OP_LT:   kind = KIND_LT;
            default: kind = KIND_GT;
        endcase
        return kind;
    endfunction

    function automatic logic [KIND_BITS-1:0] op_double(input logic [1:0] op);
        logic [KIND_BITS-1:0] kind;
        case (op)
            OP_BANG: kind = KIND_NE;
            OP_EQ:   kind = KIND_EQ;
            OP_LT:   kind = KIND_LE;
            default: kind = KIND_GE;
        endcase
        return kind;
    endfunction

endpackage

// File: design/c_subset_lexer_top.sv
// C subset lexer, top level: byte scanner with its state registers and a
// four-entry result queue. Depends on csl_pkg.
//
// Takes C source one byte per transfer on the s_ channel (s_tlast on the final byte)
// and gives tokens on the m_ channel as kind, start offset and length, one token
// per transfer, m_tlast on the last token that a byte causes. A byte is scanned in
// the cycle it is accepted and its tokens (none to three) land in the result queue
// at the same edge, so bytes that cause at most one token flow at one byte per
// cycle while m_tready is high. The input stalls while more than one token is
// queued, so the queue depth and single output port make a byte causing two or
// three tokens stall later bytes until the queue drains. Identifiers are matched
// against eleven keywords on their whole text ("void" stays an identifier),
// the operators != == <= >= are joined with one byte of lookahead, digit runs
// become integer literals and whitespace is skipped. An unknown byte gives an
// error token and later bytes are dropped until the final byte. The final byte
// flushes any held token, then gives an end token whose start is the source
// length, and the next byte begins a new source at offset 0. Offsets count
// modulo 2^POSITION_BITS.
module c_subset_lexer_top #(
    parameter int POSITION_BITS = csl_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [5:0] token_kind, [25:6] token_start,
                                   // [45:26] token_length, [47:46] zero
    output logic        m_tlast    // last_of_run
);

    localparam int FB = csl_pkg::FIELD_BITS;
    localparam int PB = POSITION_BITS;

    // Scanner state
    csl_pkg::scan_mode_t mode_reg, mode_next;
    logic [1:0]          pend_reg, pend_next;
    logic [PB-1:0]       pos_reg, pos_next;
    logic [PB-1:0]       begin_reg, begin_next;
    logic [63:0]         prefix_reg, prefix_next;
    logic                skip_reg, skip_next;

    // Result queue
    csl_pkg::token_t q_reg [4];
    logic [1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [2:0]      count_reg;

    csl_pkg::token_t res [3];
    logic [1:0]      nres;
    logic            used;
    logic            is_digit, is_alpha, is_space;
    logic [csl_pkg::KIND_BITS-1:0] sk;
    logic [PB-1:0]   word_count, end_pos;
    logic            s_acc, m_acc;

    // Token for a held run that ends just before end_pos
    function automatic csl_pkg::token_t flush_entry(input csl_pkg::scan_mode_t mode,
                                                    input logic [PB-1:0]       tb,
                                                    input logic [63:0]         prefix,
                                                    input logic [1:0]          pend,
                                                    input logic [PB-1:0]       ep);
        csl_pkg::token_t t;
        logic [PB-1:0]   len;
        logic [3:0]      len_code;
        len      = ep - tb;
        len_code = (len <= PB'(csl_pkg::PREFIX_BYTES)) ? 4'(len) : 4'hF;
        t.start  = FB'(tb);
        t.length = FB'(len);
        t.last   = 1'b0;
        case (mode)
            csl_pkg::MODE_NUMBER: t.kind = csl_pkg::KIND_INT;
            csl_pkg::MODE_WORD:   t.kind = csl_pkg::word_kind(prefix, len_code);
            default: begin
                t.kind   = csl_pkg::op_single(pend);
                t.length = FB'(1);
            end
        endcase
        return t;
    endfunction

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    // Room for a worst-case byte of three tokens
    assign s_tready = (count_reg <= 3'd1);
    assign m_tvalid = (count_reg != 3'd0);

    assign is_digit = s_tdata inside {["0":"9"]};
    assign is_alpha = s_tdata inside {["a":"z"], ["A":"Z"]};
    assign is_space = s_tdata inside {csl_pkg::CH_SPACE, [csl_pkg::CH_TAB:csl_pkg::CH_CR]};
    assign sk       = csl_pkg::single_kind(s_tdata);

    // Scan one byte: next state and the tokens it causes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end
        nres        = 2'd0;
        used        = 1'b0;
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        prefix_next = prefix_reg;
        skip_next   = skip_reg;
        word_count  = pos_reg - begin_reg;
        end_pos     = pos_reg + PB'(1);

        if (!skip_reg) begin
            if (mode_reg == csl_pkg::MODE_OPERATOR && s_tdata == csl_pkg::CH_EQ) begin
                // join with the held operator
                res[nres] = '{kind: csl_pkg::op_double(pend_reg), start: FB'(begin_reg),
                              length: FB'(2), last: 1'b0};
                nres      = nres + 2'd1;
                mode_next = csl_pkg::MODE_IDLE;
                used      = 1'b1;
            end else if (mode_reg == csl_pkg::MODE_NUMBER && is_digit) begin
                used = 1'b1;
            end else if (mode_reg == csl_pkg::MODE_WORD && (is_alpha || is_digit)) begin
                if (word_count < PB'(csl_pkg::PREFIX_BYTES)) begin
                    prefix_next = prefix_reg | (64'(s_tdata) << {word_count[2:0], 3'b000});
                end
                used = 1'b1;
            end else begin
                if (mode_reg != csl_pkg::MODE_IDLE) begin
                    res[nres] = flush_entry(mode_reg, begin_reg, prefix_reg, pend_reg, pos_reg);
                    nres      = nres + 2'd1;
                end
                mode_next = csl_pkg::MODE_IDLE;
            end

            if (!used) begin
                if (sk != csl_pkg::KIND_END) begin
                    res[nres] = '{kind: sk, start: FB'(pos_reg), length: FB'(1), last: 1'b0};
                    nres      = nres + 2'd1;
                end else if (s_tdata == csl_pkg::CH_BANG || s_tdata == csl_pkg::CH_EQ ||
                             s_tdata == csl_pkg::CH_LT || s_tdata == csl_pkg::CH_GT) begin
                    mode_next  = csl_pkg::MODE_OPERATOR;
                    begin_next = pos_reg;
                    case (s_tdata)
                        csl_pkg::CH_BANG: pend_next = csl_pkg::OP_BANG;
                        csl_pkg::CH_EQ:   pend_next = csl_pkg::OP_EQ;
                        csl_pkg::CH_LT:   pend_next = csl_pkg::OP_LT;
                        default:          pend_next = csl_pkg::OP_GT;
                    endcase
                end else if (is_digit) begin
                    mode_next  = csl_pkg::MODE_NUMBER;
                    begin_next = pos_reg;
                end else if (is_alpha) begin
                    mode_next   = csl_pkg::MODE_WORD;
                    begin_next  = pos_reg;
                    prefix_next = 64'(s_tdata);
                end else if (!is_space) begin
                    // unknown byte: report and drop until the final byte
                    res[nres] = '{kind: csl_pkg::KIND_ERROR, start: FB'(pos_reg),
                                  length: FB'(1), last: 1'b0};
                    nres      = nres + 2'd1;
                    skip_next = 1'b1;
                end
            end
        end

        if (s_tlast) begin
            // flush what this byte left held, then close the source
            if (!skip_next && mode_next != csl_pkg::MODE_IDLE) begin
                res[nres] = flush_entry(mode_next, begin_next, prefix_next, pend_next, end_pos);
                nres      = nres + 2'd1;
            end
            res[nres] = '{kind: csl_pkg::KIND_END, start: FB'(end_pos), length: '0, last: 1'b0};
            nres      = nres + 2'd1;
            mode_next   = csl_pkg::MODE_IDLE;
            pend_next   = csl_pkg::OP_BANG;
            pos_next    = '0;
            begin_next  = '0;
            prefix_next = '0;
            skip_next   = 1'b0;
        end else begin
            pos_next = end_pos;
        end

        if (nres != 2'd0) begin
            res[nres - 2'd1].last = 1'b1;
        end
    end

    // Advance scanner state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= csl_pkg::MODE_IDLE;
            pend_reg   <= csl_pkg::OP_BANG;
            pos_reg    <= '0;
            begin_reg  <= '0;
            prefix_reg <= '0;
            skip_reg   <= 1'b0;
        end else if (s_acc) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            prefix_reg <= prefix_next;
            skip_reg   <= skip_next;
        end
    end

    // Queue control: push the byte's tokens, pop one per output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_acc) begin
                wr_ptr_reg <= wr_ptr_reg + nres;
            end
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (s_acc ? 3'(nres) : 3'd0) - (m_acc ? 3'd1 : 3'd0);
        end
    end

    // Queue payload: hold entries until read
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (s_acc && 2'(i) < nres) begin
                q_reg[wr_ptr_reg + 2'(i)] <= res[i];
            end
        end
    end

    assign m_tdata = {2'b00, q_reg[rd_ptr_reg].length, q_reg[rd_ptr_reg].start,
                      q_reg[rd_ptr_reg].kind};
    assign m_tlast = q_reg[rd_ptr_reg].last;

`ifndef SYNTHESIS
    // queue never overfills
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    // the final byte returns the scanner to the start of a new source
    a_source_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> mode_reg == csl_pkg::MODE_IDLE && pos_reg == '0 && !skip_reg)
        else $error("scanner not reset after final byte");

    // while dropping bytes nothing is held
    a_skip_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> mode_reg == csl_pkg::MODE_IDLE)
        else $error("token held while skipping");

    // the last token of a byte has tlast; a byte with no token pushes nothing
    a_push_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && nres != 2'd0 |-> res[nres - 2'd1].last)
        else $error("last token of byte lacks tlast");
`endif

endmodule
